@@ sv/mtep_pkg.sv @@
// Package for the MIDI track event parser: parse phases, table entry type,
// result kinds, status constants and the status decode function.
// No dependencies.
`default_nettype none
package mtep_pkg;

    typedef enum logic [3:0] {
        PH_DELTA     = 4'd0,
        PH_STATUS    = 4'd1,
        PH_SYSEX     = 4'd2,
        PH_META_TYPE = 4'd3,
        PH_META_LEN  = 4'd4,
        PH_SKIP      = 4'd5,
        PH_DATA1     = 4'd6,
        PH_DATA2     = 4'd7
    } phase_t;

    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_ORPH  = 2'd1;
    localparam logic [1:0] KIND_FULL  = 2'd2;

    localparam logic [7:0] ST_SYSEX   = 8'hF0;
    localparam logic [7:0] ST_ESCAPE  = 8'hF7;
    localparam logic [7:0] ST_META    = 8'hFF;
    localparam logic [7:0] ST_SYSTEM  = 8'hF0;
    localparam logic [7:0] ST_NOTE_ON = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_PROGRAM = 8'hC0;
    localparam logic [7:0] ST_PRESSURE = 8'hD0;
    localparam logic [7:0] ST_CONTROL = 8'hB0;
    localparam logic [7:0] ST_MTC     = 8'hF1;
    localparam logic [7:0] ST_SONG_POS = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL = 8'hF3;
    localparam logic [7:0] DATA_MASK  = 8'h7F;

    typedef struct packed {
        logic [7:0]  key;
        logic [7:0]  vel;
        logic [31:0] start;
    } entry_t;

    typedef struct packed {
        phase_t      phase;
        logic        skip_set;
        logic [31:0] skip;
    } enter_t;

    // Decode a status byte into the phase it opens and an optional skip count.
    function automatic enter_t enter_status(input logic [7:0] st);
        enter_t r;
        r.phase    = PH_DATA1;
        r.skip_set = 1'b0;
        r.skip     = 32'd0;
        if (st == ST_SYSEX || st == ST_ESCAPE) begin
            r.phase = PH_SYSEX;
        end else if (st == ST_META) begin
            r.phase = PH_META_TYPE;
        end else if ((st & 8'hF0) == ST_SYSTEM) begin
            r.skip_set = 1'b1;
            if (st == ST_MTC || st == ST_SONG_SEL) begin
                r.skip = 32'd1;
            end else if (st == ST_SONG_POS) begin
                r.skip = 32'd2;
            end
            r.phase = (r.skip != 32'd0) ? PH_SKIP : PH_DELTA;
        end else if ((st & 8'hF0) == ST_CONTROL) begin
            r.skip_set = 1'b1;
            r.skip     = 32'd2;
            r.phase    = PH_SKIP;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/mtep_if.sv @@
// Valid/ready channel interfaces for the MIDI track event parser.
// Depends on nothing.
`default_nettype none
interface mtep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       track_start;
    modport source (output valid, output data_byte, output track_start, input ready);
    modport sink   (input valid, input data_byte, input track_start, output ready);
endinterface

interface mtep_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  note_key;
    logic [7:0]  note_velocity;
    logic [31:0] note_start;
    logic [31:0] note_length;
    modport source (output valid, output result_kind, output note_key,
                    output note_velocity, output note_start, output note_length,
                    input ready);
    modport sink   (input valid, input result_kind, input note_key,
                    input note_velocity, input note_start, input note_length,
                    output ready);
endinterface
`default_nettype wire

@@ sv/mtep_cell.sv @@
// One open-note cell: holds an entry, takes its right neighbor on shift,
// or a new entry on write. Depends on mtep_pkg.
`default_nettype none
module mtep_cell (
    input  wire logic            clk,
    input  wire logic            shift,
    input  wire mtep_pkg::entry_t nbr,
    input  wire logic            wr_en,
    input  wire mtep_pkg::entry_t wr_data,
    output      mtep_pkg::entry_t q
);
    mtep_pkg::entry_t data_reg;
    mtep_pkg::entry_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (wr_en) begin
            data_next = wr_data;
        end else if (shift) begin
            data_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;
endmodule
`default_nettype wire

@@ sv/midi_track_event_parser.sv @@
// Top level of the MIDI track event parser: byte parser, open-note cell row
// and result register. Depends on mtep_pkg, mtep_if and mtep_cell.
//
// Takes one track byte per beat and emits at most one result beat per byte.
// A note-off (or note-on with velocity zero) rotates the open-note row through
// its head cell once, one cell per cycle, so it holds the input until every
// open note (up to NOTE_SLOTS, 64 by default) has been visited.
// Open notes live in a row of cells kept in
// arrival order; the head cell is compared against the key and the current
// track time, a match is dropped and reported, the rest go back to the tail.
// A byte is taken only when no scan runs and the result register is free or
// draining in the same cycle.
`default_nettype none
module midi_track_event_parser #(
    parameter int NOTE_SLOTS = 64
) (
    input wire logic clk,
    input wire logic rst_n,
    mtep_in_if.sink  in_ch,
    mtep_out_if.source out_ch
);
    localparam int CW = $clog2(NOTE_SLOTS + 1);
    localparam int IW = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;

    // parser state
    mtep_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  running_reg, running_next;
    logic [7:0]  cur_reg, cur_next;
    logic [7:0]  first_reg, first_next;
    logic [31:0] time_reg, time_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] skip_reg, skip_next;

    // table control
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic          busy_reg, busy_next;
    logic          found_reg, found_next;
    logic [7:0]    key_reg, key_next;

    // result register
    logic        ovalid_reg, ovalid_next;
    logic [1:0]  okind_reg, okind_next;
    logic [7:0]  okey_reg, okey_next;
    logic [7:0]  ovel_reg, ovel_next;
    logic [31:0] ostart_reg, ostart_next;
    logic [31:0] olen_reg, olen_next;

    logic accept;
    logic on_req, off_req;
    logic [7:0] op_key, op_vel;

    // cell row
    mtep_pkg::entry_t cell_q [NOTE_SLOTS];
    logic             shift;
    logic             wr_en;
    logic [IW-1:0]    wr_idx;
    mtep_pkg::entry_t wr_data;
    logic             hit;

    assign in_ch.ready = !busy_reg && (!ovalid_reg || out_ch.ready);
    assign accept = in_ch.valid && in_ch.ready;

    // Parser: decode one byte, including running status re-entry.
    always_comb
    begin
        mtep_pkg::phase_t bp;
        mtep_pkg::phase_t pp;
        mtep_pkg::enter_t ent;
        logic [7:0]  b;
        logic [7:0]  hi;
        logic [7:0]  term;
        logic [31:0] num;
        logic [31:0] dec;
        logic        run;

        b    = in_ch.data_byte;
        bp   = phase_reg;
        run  = 1'b0;
        pp   = phase_reg;
        ent  = '0;
        hi   = 8'd0;
        term = 8'd0;
        num  = 32'd0;
        dec  = 32'd0;

        phase_next   = phase_reg;
        running_next = running_reg;
        cur_next     = cur_reg;
        first_next   = first_reg;
        time_next    = time_reg;
        acc_next     = acc_reg;
        skip_next    = skip_reg;
        on_req       = 1'b0;
        off_req      = 1'b0;
        op_key       = first_reg;
        op_vel       = b;

        if (accept) begin
            if (in_ch.track_start) begin
                bp         = mtep_pkg::PH_DELTA;
                cur_next   = 8'd0;
                first_next = 8'd0;
                time_next  = 32'd0;
                acc_next   = 32'd0;
                skip_next  = 32'd0;
            end
            if (bp == mtep_pkg::PH_STATUS) begin
                if (b[7]) begin
                    running_next = b;
                    ent = mtep_pkg::enter_status(b);
                    cur_next   = b;
                    phase_next = ent.phase;
                    if (ent.skip_set) begin
                        skip_next = ent.skip;
                    end
                end else begin
                    ent = mtep_pkg::enter_status(running_reg);
                    cur_next = running_reg;
                    if (ent.skip_set) begin
                        skip_next = ent.skip;
                    end
                    pp  = ent.phase;
                    run = 1'b1;
                end
            end else begin
                pp  = bp;
                run = 1'b1;
            end

            if (run) begin
                hi  = cur_next & 8'hF0;
                num = {acc_next[24:0], 7'd0} + {24'd0, b & mtep_pkg::DATA_MASK};
                phase_next = pp;
                case (pp)
                    mtep_pkg::PH_DELTA:
                    begin
                        acc_next = num;
                        if (!b[7]) begin
                            time_next  = time_next + num;
                            acc_next   = 32'd0;
                            phase_next = mtep_pkg::PH_STATUS;
                        end
                    end
                    mtep_pkg::PH_SYSEX:
                    begin
                        term = (cur_next == mtep_pkg::ST_SYSEX) ? mtep_pkg::ST_ESCAPE
                                                                 : mtep_pkg::ST_SYSEX;
                        if (b == term) begin
                            phase_next = mtep_pkg::PH_DELTA;
                        end
                    end
                    mtep_pkg::PH_META_TYPE:
                    begin
                        acc_next   = 32'd0;
                        phase_next = mtep_pkg::PH_META_LEN;
                    end
                    mtep_pkg::PH_META_LEN:
                    begin
                        acc_next = num;
                        if (!b[7]) begin
                            skip_next  = num;
                            acc_next   = 32'd0;
                            phase_next = (num != 32'd0) ? mtep_pkg::PH_SKIP
                                                        : mtep_pkg::PH_DELTA;
                        end
                    end
                    mtep_pkg::PH_SKIP:
                    begin
                        dec = (skip_next != 32'd0) ? skip_next - 32'd1 : 32'd0;
                        skip_next = dec;
                        if (dec == 32'd0) begin
                            phase_next = mtep_pkg::PH_DELTA;
                        end
                    end
                    mtep_pkg::PH_DATA1:
                    begin
                        first_next = b;
                        phase_next = (hi == mtep_pkg::ST_PROGRAM || hi == mtep_pkg::ST_PRESSURE)
                                     ? mtep_pkg::PH_DELTA : mtep_pkg::PH_DATA2;
                    end
                    mtep_pkg::PH_DATA2:
                    begin
                        phase_next = mtep_pkg::PH_DELTA;
                        op_key = first_next;
                        if (hi == mtep_pkg::ST_NOTE_ON && b != 8'd0) begin
                            on_req = 1'b1;
                        end else if (hi == mtep_pkg::ST_NOTE_ON
                                     || hi == mtep_pkg::ST_NOTE_OFF) begin
                            off_req = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = mtep_pkg::PH_DELTA;
                    end
                endcase
            end
        end
    end

    // Table control: insert, start a scan, rotate the row during a scan.
    assign hit = !found_reg && (cell_q[0].key == key_reg) && (cell_q[0].start < time_reg);

    always_comb
    begin
        count_next  = count_reg;
        steps_next  = steps_reg;
        busy_next   = busy_reg;
        found_next  = found_reg;
        key_next    = key_reg;
        shift       = 1'b0;
        wr_en       = 1'b0;
        wr_idx      = count_reg[IW-1:0];
        wr_data     = '0;
        ovalid_next = ovalid_reg && !out_ch.ready;
        okind_next  = okind_reg;
        okey_next   = okey_reg;
        ovel_next   = ovel_reg;
        ostart_next = ostart_reg;
        olen_next   = olen_reg;

        if (busy_reg) begin
            shift = 1'b1;
            if (hit) begin
                // drop the matched head and report it
                count_next  = count_reg - CW'(1);
                found_next  = 1'b1;
                ovalid_next = 1'b1;
                okind_next  = mtep_pkg::KIND_DONE;
                okey_next   = cell_q[0].key;
                ovel_next   = cell_q[0].vel;
                ostart_next = cell_q[0].start;
                olen_next   = time_reg - cell_q[0].start;
            end else begin
                // reinsert the head at the tail
                wr_en   = 1'b1;
                wr_idx  = IW'(count_reg - CW'(1));
                wr_data = cell_q[0];
            end
            steps_next = steps_reg - CW'(1);
            if (steps_reg == CW'(1)) begin
                busy_next = 1'b0;
                if (!found_reg && !hit) begin
                    ovalid_next = 1'b1;
                    okind_next  = mtep_pkg::KIND_ORPH;
                    okey_next   = key_reg;
                    ovel_next   = 8'd0;
                    ostart_next = time_reg;
                    olen_next   = 32'd0;
                end
            end
        end else if (accept) begin
            if (in_ch.track_start) begin
                count_next = '0;
            end
            if (on_req) begin
                if (count_next == CW'(NOTE_SLOTS)) begin
                    ovalid_next = 1'b1;
                    okind_next  = mtep_pkg::KIND_FULL;
                    okey_next   = op_key;
                    ovel_next   = op_vel;
                    ostart_next = time_next;
                    olen_next   = 32'd0;
                end else begin
                    wr_en      = 1'b1;
                    wr_idx     = count_next[IW-1:0];
                    wr_data    = '{key: op_key, vel: op_vel, start: time_next};
                    count_next = count_next + CW'(1);
                end
            end else if (off_req) begin
                if (count_next == '0) begin
                    ovalid_next = 1'b1;
                    okind_next  = mtep_pkg::KIND_ORPH;
                    okey_next   = op_key;
                    ovel_next   = 8'd0;
                    ostart_next = time_next;
                    olen_next   = 32'd0;
                end else begin
                    busy_next  = 1'b1;
                    found_next = 1'b0;
                    steps_next = count_next;
                    key_next   = op_key;
                end
            end
        end
    end

    // Cell row: each cell but the last takes its right neighbor on shift.
    genvar j;
    generate
        for (j = 0; j < NOTE_SLOTS; j++) begin : g_cell
            mtep_pkg::entry_t nbr;
            if (j + 1 < NOTE_SLOTS) begin : g_mid
                assign nbr = cell_q[j + 1];
            end else begin : g_end
                assign nbr = cell_q[j];
            end
            mtep_cell u_cell (
                .clk     (clk),
                .shift   (shift),
                .nbr     (nbr),
                .wr_en   (wr_en && (wr_idx == IW'(j))),
                .wr_data (wr_data),
                .q       (cell_q[j])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= mtep_pkg::PH_DELTA;
            running_reg <= 8'd0;
            cur_reg     <= 8'd0;
            first_reg   <= 8'd0;
            time_reg    <= 32'd0;
            acc_reg     <= 32'd0;
            skip_reg    <= 32'd0;
            count_reg   <= '0;
            steps_reg   <= '0;
            busy_reg    <= 1'b0;
            found_reg   <= 1'b0;
            key_reg     <= 8'd0;
            ovalid_reg  <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            running_reg <= running_next;
            cur_reg     <= cur_next;
            first_reg   <= first_next;
            time_reg    <= time_next;
            acc_reg     <= acc_next;
            skip_reg    <= skip_next;
            count_reg   <= count_next;
            steps_reg   <= steps_next;
            busy_reg    <= busy_next;
            found_reg   <= found_next;
            key_reg     <= key_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    // hold result payload
    always_ff @(posedge clk)
    begin
        okind_reg  <= okind_next;
        okey_reg   <= okey_next;
        ovel_reg   <= ovel_next;
        ostart_reg <= ostart_next;
        olen_reg   <= olen_next;
    end

    assign out_ch.valid         = ovalid_reg;
    assign out_ch.result_kind   = okind_reg;
    assign out_ch.note_key      = okey_reg;
    assign out_ch.note_velocity = ovel_reg;
    assign out_ch.note_start    = ostart_reg;
    assign out_ch.note_length   = olen_reg;
endmodule
`default_nettype wire
